// ----- src/frame_sync_search_bcd_header_macros.svh -----
// Assertion helpers for the frame sync search RTL.
`ifndef FRAME_SYNC_SEARCH_BCD_HEADER_MACROS_SVH
`define FRAME_SYNC_SEARCH_BCD_HEADER_MACROS_SVH

// same-cycle implication, checked out of reset
`define FSSBH_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FSSBH_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/fssbh_pkg.sv -----
`default_nettype none

package fssbh_pkg;

    localparam int FRAME_WORDS   = 2504;
    localparam int HISTORY_DEPTH = 4096;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);

    localparam int WORD_W   = 32;
    localparam int IDX_W    = 17;
    localparam int LIMIT_W  = 16;
    localparam int MJD_W    = 17;
    localparam int OFFSET_W = 19;
    localparam int FNUM_W   = 15;
    localparam int SECS_W   = 18;
    localparam int DAYD_W   = 11;   // three BCD digits, unchecked: up to 1665
    localparam int X_W      = 19;   // signed mjd - d + 500
    localparam int Q_W      = 9;    // signed quotient, -1 .. 131
    localparam int DAY_W    = 17;
    localparam int TDATA_W  = 72;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [IDX_W-1:0]   IDX_MAX      = {IDX_W{1'b1}};
    localparam logic [WORD_W-1:0]  SYNC_WORD    = 32'hABADDEED;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 16'd22528;
    localparam logic [MJD_W-1:0]   MJD_RESET    = 17'd56000;

    // x / 1000 for 0 <= x < 2^18: (x * 134218) >> 27
    localparam int RECIP       = 134218;
    localparam int RECIP_SHIFT = 27;
    localparam int PROD_W      = 36;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEARCH_MODE  = 2'd0,
        CFG_SEARCH_LIMIT = 2'd1,
        CFG_CURRENT_MJD  = 2'd2
    } cfg_index_t;

    // history entry at address a: sync flag of word a and the two words after it
    typedef struct packed {
        logic              sync;
        logic [WORD_W-1:0] h1;
        logic [WORD_W-1:0] h2;
    } hist_entry_t;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  offset;
        logic [WORD_W-1:0] h1;
        logic [WORD_W-1:0] h2;
    } emit_t;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] byte_offset;
        logic [FNUM_W-1:0]   frame_number;
        logic [SECS_W-1:0]   seconds;
        logic [DAY_W-1:0]    day_number;
    } result_t;

endpackage

`default_nettype wire

// ----- src/fssbh_hist.sv -----
`default_nettype none

module fssbh_hist (
    input  wire logic                                aclk,
    input  wire logic                                wr_en,
    input  wire logic [fssbh_pkg::WORD_W-1:0]        wr_word,
    input  wire logic [fssbh_pkg::IDX_W-1:0]         wr_idx,
    input  wire logic                                rd_en,
    input  wire logic [fssbh_pkg::HIST_AW-1:0]       rd_addr,
    output fssbh_pkg::hist_entry_t                   rd_entry
);

    logic [fssbh_pkg::WORD_W-1:0] prev1_reg;
    logic [fssbh_pkg::WORD_W-1:0] prev2_reg;
    fssbh_pkg::hist_entry_t       mem [fssbh_pkg::HISTORY_DEPTH];
    fssbh_pkg::hist_entry_t       rd_entry_reg;
    logic [fssbh_pkg::IDX_W-1:0]  wr_back;
    logic                         wr_ok;

    // entry for word j-2 is complete once word j arrives
    assign wr_back = wr_idx - fssbh_pkg::IDX_W'(2);
    assign wr_ok   = wr_idx >= fssbh_pkg::IDX_W'(2);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            prev2_reg <= prev1_reg;
            prev1_reg <= wr_word;
            if (wr_ok) begin
                mem[wr_back[fssbh_pkg::HIST_AW-1:0]] <= '{
                    sync: (prev2_reg == fssbh_pkg::SYNC_WORD),
                    h1:   prev1_reg,
                    h2:   wr_word
                };
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

`default_nettype wire

// ----- src/fssbh_decode.sv -----
`default_nettype none

module fssbh_decode (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          adv,
    input  wire logic                          in_valid,
    input  wire fssbh_pkg::emit_t              in_emit,
    input  wire logic [fssbh_pkg::MJD_W-1:0]   mjd,
    output logic                               out_valid,
    output fssbh_pkg::result_t                 out_result
);

    // stage 3: BCD digits and the rounding term
    logic                            v3_reg;
    logic                            found3_reg;
    logic [fssbh_pkg::OFFSET_W-1:0]  boff3_reg;
    logic [fssbh_pkg::FNUM_W-1:0]    fnum3_reg;
    logic [fssbh_pkg::SECS_W-1:0]    secs3_reg;
    logic [fssbh_pkg::DAYD_W-1:0]    d3_reg;
    logic signed [fssbh_pkg::X_W-1:0] x3_reg;

    // stage 4: quotient
    logic                            v4_reg;
    logic                            found4_reg;
    logic [fssbh_pkg::OFFSET_W-1:0]  boff4_reg;
    logic [fssbh_pkg::FNUM_W-1:0]    fnum4_reg;
    logic [fssbh_pkg::SECS_W-1:0]    secs4_reg;
    logic [fssbh_pkg::DAYD_W-1:0]    d4_reg;
    logic signed [fssbh_pkg::Q_W-1:0] q4_reg;

    logic                            out_valid_reg;
    fssbh_pkg::result_t              out_result_reg;

    logic [fssbh_pkg::SECS_W-1:0]    secs_next;
    logic [fssbh_pkg::DAYD_W-1:0]    d_next;
    logic signed [fssbh_pkg::X_W-1:0] x_next;
    logic [fssbh_pkg::PROD_W-1:0]    prod;
    logic signed [fssbh_pkg::Q_W-1:0] q_next;
    logic signed [fssbh_pkg::X_W-1:0] kilo;
    logic [fssbh_pkg::DAY_W-1:0]     day_next;

    always_comb begin
        secs_next = fssbh_pkg::SECS_W'(in_emit.h2[3:0])
                  + fssbh_pkg::SECS_W'(in_emit.h2[7:4])   * fssbh_pkg::SECS_W'(10)
                  + fssbh_pkg::SECS_W'(in_emit.h2[11:8])  * fssbh_pkg::SECS_W'(100)
                  + fssbh_pkg::SECS_W'(in_emit.h2[15:12]) * fssbh_pkg::SECS_W'(1000)
                  + fssbh_pkg::SECS_W'(in_emit.h2[19:16]) * fssbh_pkg::SECS_W'(10000);
        d_next    = fssbh_pkg::DAYD_W'(in_emit.h2[23:20])
                  + fssbh_pkg::DAYD_W'(in_emit.h2[27:24]) * fssbh_pkg::DAYD_W'(10)
                  + fssbh_pkg::DAYD_W'(in_emit.h2[31:28]) * fssbh_pkg::DAYD_W'(100);
        x_next    = $signed({2'b00, mjd}) + fssbh_pkg::X_W'(500)
                  - $signed({8'b0, d_next});
    end

    // truncation toward zero: a negative x lies above -2000, so -1 or 0
    always_comb begin
        prod = fssbh_pkg::PROD_W'(x3_reg[fssbh_pkg::X_W-2:0])
             * fssbh_pkg::PROD_W'(fssbh_pkg::RECIP);
        if (x3_reg < 0) begin
            q_next = (x3_reg <= -fssbh_pkg::X_W'(1000)) ? -fssbh_pkg::Q_W'(1)
                                                         : fssbh_pkg::Q_W'(0);
        end else begin
            q_next = $signed(prod[fssbh_pkg::RECIP_SHIFT+fssbh_pkg::Q_W-1:
                                  fssbh_pkg::RECIP_SHIFT]);
        end
    end

    always_comb begin
        kilo     = fssbh_pkg::X_W'(q4_reg) * fssbh_pkg::X_W'(1000);
        day_next = fssbh_pkg::DAY_W'(d4_reg) + kilo[fssbh_pkg::DAY_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v3_reg        <= in_valid;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            found3_reg <= in_emit.found;
            boff3_reg  <= {in_emit.offset, 2'b00};
            fnum3_reg  <= in_emit.h1[fssbh_pkg::FNUM_W-1:0];
            secs3_reg  <= secs_next;
            d3_reg     <= d_next;
            x3_reg     <= x_next;

            found4_reg <= found3_reg;
            boff4_reg  <= boff3_reg;
            fnum4_reg  <= fnum3_reg;
            secs4_reg  <= secs3_reg;
            d4_reg     <= d3_reg;
            q4_reg     <= q_next;

            if (found4_reg) begin
                out_result_reg <= '{
                    found:        1'b1,
                    byte_offset:  boff4_reg,
                    frame_number: fnum4_reg,
                    seconds:      secs4_reg,
                    day_number:   day_next
                };
            end else begin
                out_result_reg <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

`default_nettype wire

// ----- src/frame_sync_search_bcd_header.sv -----
// Frame sync search with header time decode.
// Input stream (s_*): one 32-bit word per request in s_tdata, s_tlast on the
// final word of a search buffer. Results (m_*): m_tuser is the found flag,
// m_tdata holds byte_offset, frame_number, seconds, day_number from bit 0 up.
// Configuration (cfg_*): always ready; index 0 search_mode, 1 search_limit,
// 2 current_mjd. Write it only while the block is idle.
// First mode gives one result on the word that confirms the first sync pair
// (or found 0 on the last word); last mode gives one result on the last word.
// Throughput: one word per cycle while m_tready does not stall the pipeline.
// A result passes through history read, search state, digit decode, divide
// by 1000 and day assembly, each registered, before it appears on m_*.
// History is a 4096-entry memory with one write and one read port; each entry
// packs a sync flag with the two following words, so one read a cycle serves
// both the sync check and the header fetch.
// Reset clears search state and restores the register defaults; the history
// needs no clearing. A stalled m_tready freezes the whole pipeline and
// s_tready falls in the same cycle.
`default_nettype none
`include "frame_sync_search_bcd_header_macros.svh"

module frame_sync_search_bcd_header (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [fssbh_pkg::WORD_W-1:0]       s_tdata,   // data_word
    input  wire logic                               s_tlast,   // last_word
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // byte_offset[18:0], frame_number[33:19], seconds[51:34],
    // day_number[68:52], zero pad[71:69]
    output logic [fssbh_pkg::TDATA_W-1:0]           m_tdata,
    output logic                                    m_tuser,   // found
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [fssbh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fssbh_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                            mode_reg;
    logic [fssbh_pkg::LIMIT_W-1:0]   limit_reg;
    logic [fssbh_pkg::MJD_W-1:0]     mjd_reg;

    logic                            adv;
    logic                            accept;

    // stage A
    logic [fssbh_pkg::IDX_W-1:0]     idx_reg;
    logic [fssbh_pkg::IDX_W-1:0]     start_a;
    logic                            cand_a;

    // stage 1
    logic                            s1_valid_reg;
    logic [fssbh_pkg::WORD_W-1:0]    s1_word_reg;
    logic                            s1_last_reg;
    logic [fssbh_pkg::IDX_W-1:0]     s1_idx_reg;
    logic [fssbh_pkg::IDX_W-1:0]     s1_start_reg;
    logic                            s1_cand_reg;
    fssbh_pkg::hist_entry_t          hist_q;

    // search state
    logic                            done_reg,  done_next;
    logic                            have_reg,  have_next;
    logic [fssbh_pkg::IDX_W-1:0]     coff_reg,  coff_next;
    logic [fssbh_pkg::WORD_W-1:0]    hdr0_reg,  hdr0_next;
    logic [fssbh_pkg::WORD_W-1:0]    hdr1_reg,  hdr1_next;
    logic [1:0]                      cd_reg,    cd_next;
    logic                            pair_b;
    logic                            emit_b;
    fssbh_pkg::emit_t                emit_next;
    logic                            e_valid_reg;
    fssbh_pkg::emit_t                emit_reg;

    fssbh_pkg::result_t              result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            limit_reg <= fssbh_pkg::LIMIT_RESET;
            mjd_reg   <= fssbh_pkg::MJD_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                fssbh_pkg::CFG_SEARCH_MODE:  mode_reg  <= cfg_data[0];
                fssbh_pkg::CFG_SEARCH_LIMIT: limit_reg <= cfg_data[fssbh_pkg::LIMIT_W-1:0];
                fssbh_pkg::CFG_CURRENT_MJD:  mjd_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    // candidate start one frame back, checked against the limit here
    assign start_a = idx_reg - fssbh_pkg::IDX_W'(fssbh_pkg::FRAME_WORDS);
    assign cand_a  = (idx_reg >= fssbh_pkg::IDX_W'(fssbh_pkg::FRAME_WORDS))
                  && (start_a < fssbh_pkg::IDX_W'(limit_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (adv) begin
                s1_valid_reg <= s_tvalid;
            end
            if (accept) begin
                if (s_tlast) begin
                    idx_reg <= '0;
                end else if (idx_reg != fssbh_pkg::IDX_MAX) begin
                    idx_reg <= idx_reg + fssbh_pkg::IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_word_reg  <= s_tdata;
            s1_last_reg  <= s_tlast;
            s1_idx_reg   <= idx_reg;
            s1_start_reg <= start_a;
            s1_cand_reg  <= cand_a;
        end
    end

    fssbh_hist u_hist (
        .aclk     (aclk),
        .wr_en    (accept),
        .wr_word  (s_tdata),
        .wr_idx   (idx_reg),
        .rd_en    (adv),
        .rd_addr  (start_a[fssbh_pkg::HIST_AW-1:0]),
        .rd_entry (hist_q)
    );

    assign pair_b = s1_cand_reg && (s1_word_reg == fssbh_pkg::SYNC_WORD) && hist_q.sync;

    always_comb begin
        done_next = done_reg;
        have_next = have_reg;
        coff_next = coff_reg;
        hdr0_next = hdr0_reg;
        hdr1_next = hdr1_reg;
        cd_next   = cd_reg;
        emit_b    = 1'b0;
        emit_next = '0;
        if (s1_valid_reg) begin
            // header capture comes before the pair check: a new pair wins
            if (mode_reg && cd_reg != 2'd0) begin
                if (cd_reg == 2'd2) begin
                    hdr0_next = s1_word_reg;
                    cd_next   = 2'd1;
                end else begin
                    hdr1_next = s1_word_reg;
                    cd_next   = 2'd0;
                end
            end
            if (!mode_reg) begin
                if (!done_reg) begin
                    if (pair_b) begin
                        emit_b    = 1'b1;
                        emit_next = '{found: 1'b1, offset: s1_start_reg,
                                      h1: hist_q.h1, h2: hist_q.h2};
                        done_next = 1'b1;
                    end else if (s1_last_reg) begin
                        emit_b = 1'b1;
                    end
                end
            end else begin
                if (pair_b) begin
                    have_next = 1'b1;
                    coff_next = s1_idx_reg;
                    hdr0_next = '0;
                    hdr1_next = '0;
                    cd_next   = 2'd2;
                end
                if (s1_last_reg) begin
                    emit_b = 1'b1;
                    if (have_next) begin
                        emit_next = '{found: 1'b1, offset: coff_next,
                                      h1: hdr0_next, h2: hdr1_next};
                    end
                end
            end
            if (s1_last_reg) begin
                done_next = 1'b0;
                have_next = 1'b0;
                coff_next = '0;
                hdr0_next = '0;
                hdr1_next = '0;
                cd_next   = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg    <= 1'b0;
            have_reg    <= 1'b0;
            coff_reg    <= '0;
            hdr0_reg    <= '0;
            hdr1_reg    <= '0;
            cd_reg      <= 2'd0;
            e_valid_reg <= 1'b0;
        end else if (adv) begin
            done_reg    <= done_next;
            have_reg    <= have_next;
            coff_reg    <= coff_next;
            hdr0_reg    <= hdr0_next;
            hdr1_reg    <= hdr1_next;
            cd_reg      <= cd_next;
            e_valid_reg <= emit_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            emit_reg <= emit_next;
        end
    end

    fssbh_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (e_valid_reg),
        .in_emit    (emit_reg),
        .mjd        (mjd_reg),
        .out_valid  (m_tvalid),
        .out_result (result)
    );

    assign m_tuser = result.found;
    assign m_tdata = {3'b000, result.day_number, result.seconds,
                      result.frame_number, result.byte_offset};

    `FSSBH_ASSERT_NEXT(a_last_mode_reports, aclk, aresetn, mode_reg && adv && s1_valid_reg && s1_last_reg, e_valid_reg, "last word in last mode gave no request")
    `FSSBH_ASSERT_NEXT(a_index_rearm, aclk, aresetn, accept && s_tlast, idx_reg == '0, "word index not cleared after last word")
    `FSSBH_ASSERT_IMPL(a_capture_has_cand, aclk, aresetn, cd_reg != 2'd0, have_reg, "header capture without a held pair")
    `FSSBH_ASSERT_IMPL(a_fail_is_zero, aclk, aresetn, e_valid_reg && !emit_reg.found, emit_reg.offset == '0 && emit_reg.h2 == '0, "failure request carries data")

endmodule

`default_nettype wire

// ----- sim/frame_sync_checker.sv -----
module frame_sync_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [fssbh_pkg::WORD_W-1:0]         s_tdata,
    input  logic                                 s_tlast,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [fssbh_pkg::TDATA_W-1:0]        m_tdata,
    input  logic                                 m_tuser,
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [fssbh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fssbh_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                   mismatches,
    output int                                   reports_seen,
    output int                                   reports_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import fssbh_pkg::*;

    // register copies
    logic                 last_mode;
    logic [LIMIT_W-1:0]   start_limit;
    logic [MJD_W-1:0]     today_mjd;

    // search state
    logic [WORD_W-1:0]    words_seen [HISTORY_DEPTH];
    logic [IDX_W-1:0]     word_pos;
    bit                   first_reported;
    bit                   pair_held;
    int                   held_pos;
    logic [WORD_W-1:0]    held_h1;
    logic [WORD_W-1:0]    held_h2;
    logic [1:0]           headers_left;

    result_t              pending_reports [$];

    initial begin
        mismatches   = 0;
        reports_seen = 0;
        reports_due  = 0;
    end

    function automatic void restart_search();
        word_pos       = '0;
        first_reported = 1'b0;
        pair_held      = 1'b0;
        held_pos       = 0;
        held_h1        = '0;
        held_h2        = '0;
        headers_left   = 2'd0;
    endfunction

    // frame number from header 1; seconds and day digits from header 2
    function automatic result_t decode_report(input int pos, input logic [WORD_W-1:0] h1,
                                              input logic [WORD_W-1:0] h2);
        result_t     r;
        int          secs;
        int          digits;
        int          weight;
        int          x;
        int          day;
        logic [31:0] bytes;
        logic [31:0] day_bits;
        logic [31:0] secs_bits;
        secs   = 0;
        weight = 1;
        for (int n = 0; n < 5; n++) begin
            secs   = secs + int'(h2[4*n +: 4]) * weight;
            weight = weight * 10;
        end
        digits = 0;
        weight = 1;
        for (int n = 0; n < 3; n++) begin
            digits = digits + int'(h2[20 + 4*n +: 4]) * weight;
            weight = weight * 10;
        end
        // thousands restored from today's day number, rounded to nearest
        x         = int'(today_mjd) - digits + 500;
        day       = digits + 1000 * (x / 1000);
        bytes     = pos * 4;
        day_bits  = day;
        secs_bits = secs;
        r.found        = 1'b1;
        r.byte_offset  = bytes[OFFSET_W-1:0];
        r.frame_number = h1[FNUM_W-1:0];
        r.seconds      = secs_bits[SECS_W-1:0];
        r.day_number   = day_bits[DAY_W-1:0];
        return r;
    endfunction

    function automatic void advance_search(input logic [WORD_W-1:0] w, input logic fin);
        int      j;
        int      s;
        bit      pair;
        result_t none;
        j    = int'(word_pos);
        s    = j - FRAME_WORDS;
        none = '0;
        pair = 1'b0;
        if (last_mode && headers_left != 2'd0) begin
            if (headers_left == 2'd2) held_h1 = w;
            else held_h2 = w;
            headers_left = headers_left - 2'd1;
        end
        if (s >= 0)
            pair = s < int'(start_limit) && w == SYNC_WORD
                   && words_seen[s % HISTORY_DEPTH] == SYNC_WORD;
        if (!last_mode) begin
            if (!first_reported) begin
                if (pair) begin
                    pending_reports.push_back(decode_report(s,
                        words_seen[(s + 1) % HISTORY_DEPTH],
                        words_seen[(s + 2) % HISTORY_DEPTH]));
                    first_reported = 1'b1;
                end else if (fin) begin
                    pending_reports.push_back(none);
                end
            end
        end else begin
            // a newer pair drops whatever headers were being gathered
            if (pair) begin
                pair_held    = 1'b1;
                held_pos     = j;
                held_h1      = '0;
                held_h2      = '0;
                headers_left = 2'd2;
            end
            if (fin) begin
                if (pair_held)
                    pending_reports.push_back(decode_report(held_pos, held_h1, held_h2));
                else
                    pending_reports.push_back(none);
            end
        end
        words_seen[j % HISTORY_DEPTH] = w;
        if (word_pos != IDX_MAX) word_pos = word_pos + 1'b1;
        if (fin) restart_search();
    endfunction

    task automatic note_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s wrong, got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_report();
        result_t    want;
        result_t    got;
        logic [2:0] pad;
        reports_seen++;
        if (pending_reports.size() == 0) begin
            note_mismatch("unrequested report (found flag)", m_tuser, 0);
            return;
        end
        want             = pending_reports.pop_front();
        got.found        = m_tuser;
        got.byte_offset  = m_tdata[18:0];
        got.frame_number = m_tdata[33:19];
        got.seconds      = m_tdata[51:34];
        got.day_number   = m_tdata[68:52];
        pad              = m_tdata[71:69];
        if (got.found !== want.found)
            note_mismatch("found", got.found, want.found);
        if (got.byte_offset !== want.byte_offset)
            note_mismatch("byte_offset", got.byte_offset, want.byte_offset);
        if (got.frame_number !== want.frame_number)
            note_mismatch("frame_number", got.frame_number, want.frame_number);
        if (got.seconds !== want.seconds)
            note_mismatch("seconds", got.seconds, want.seconds);
        if (got.day_number !== want.day_number)
            note_mismatch("day_number", got.day_number, want.day_number);
        if (pad !== 3'b000)
            note_mismatch("tdata padding", pad, 0);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            last_mode   = 1'b0;
            start_limit = LIMIT_RESET;
            today_mjd   = MJD_RESET;
            restart_search();
            pending_reports.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SEARCH_MODE:  last_mode   = cfg_data[0];
                    CFG_SEARCH_LIMIT: start_limit = cfg_data[LIMIT_W-1:0];
                    CFG_CURRENT_MJD:  today_mjd   = cfg_data[MJD_W-1:0];
                    default: ;
                endcase
            end
            // a report cannot stem from a request taken at the same edge
            if (m_tvalid && m_tready) check_report();
            if (s_tvalid && s_tready) advance_search(s_tdata, s_tlast);
        end
        reports_due = pending_reports.size();
    end

endmodule

// ----- sim/tb_frame_sync_search_bcd_header.sv -----
module tb_frame_sync_search_bcd_header;
    timeunit 1ns;
    timeprecision 1ps;

    import fssbh_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 1_500_000;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [WORD_W-1:0]       s_tdata;
    logic                    s_tlast;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [TDATA_W-1:0]      m_tdata;
    logic                    m_tuser;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    int  mismatches;
    int  reports_seen;
    int  reports_due;
    int  cycle_count;
    int  words_sent;
    int  streams_sent;
    int  reg_writes;
    bit  no_idle;
    bit  sync_mark [int];

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    frame_sync_search_bcd_header dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_sync_checker u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .reports_seen (reports_seen),
        .reports_due  (reports_due)
    );

    // result sink back-pressure
    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(99) >= 12);
    end

    initial begin : watchdog
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge aclk);
        $display("TB_ERROR");
        $finish;
    end

    function automatic bit is_sync(input int k);
        return sync_mark.exists(k) || sync_mark.exists(k - FRAME_WORDS);
    endfunction

    function automatic logic [WORD_W-1:0] header_word();
        logic [WORD_W-1:0] w;
        case ($urandom_range(3))
            0: w = '0;
            1: w = '1;
            2: begin
                for (int n = 0; n < 8; n++) w[4*n +: 4] = 4'($urandom_range(9));
            end
            default: w = $urandom();
        endcase
        return w;
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] w, input logic fin);
        if (!no_idle && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < 12);
        end
        s_tdata  <= w;
        s_tlast  <= fin;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        words_sent++;
    endtask

    // hold requests until every report is in and the pipe has moved on
    task automatic wait_idle();
        int moved;
        moved = 0;
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (reports_due != 0) @(negedge aclk);
        while (moved < 8) begin
            @(negedge aclk);
            if (m_tready) moved++;
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
        cfg_index <= idx;
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        reg_writes++;
    endtask

    task automatic set_regs(input logic mode, input int limit, input int mjd);
        wait_idle();
        write_reg(CFG_SEARCH_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_SEARCH_LIMIT, CFG_DATA_W'(limit));
        write_reg(CFG_CURRENT_MJD, CFG_DATA_W'(mjd));
    endtask

    task automatic random_regs();
        int limit;
        int mjd;
        case ($urandom_range(3))
            0: limit = 0;
            1: limit = 65535;
            2: limit = $urandom_range(0, 300);
            default: limit = $urandom_range(0, 65535);
        endcase
        case ($urandom_range(3))
            0: mjd = 1200;
            1: mjd = 99999;
            default: mjd = $urandom_range(1200, 99999);
        endcase
        set_regs(1'($urandom_range(1)), limit, mjd);
    endtask

    // marked indices carry a sync word with its partner one frame later
    task automatic send_stream(input int len, input int noise_pct, input int switch_at);
        logic [WORD_W-1:0] w;
        for (int k = 0; k < len; k++) begin
            if (k == switch_at) begin
                wait_idle();
                write_reg(CFG_SEARCH_MODE, CFG_DATA_W'($urandom_range(1)));
                if ($urandom_range(1))
                    write_reg(CFG_SEARCH_LIMIT, CFG_DATA_W'($urandom_range(0, 400)));
            end
            if (is_sync(k))
                w = SYNC_WORD;
            else if (is_sync(k - 1) || is_sync(k - 2))
                w = header_word();
            else if ($urandom_range(99) < noise_pct)
                w = SYNC_WORD;
            else
                w = $urandom();
            send_word(w, k == len - 1);
        end
        sync_mark.delete();
        streams_sent++;
    endtask

    initial begin
        int len;
        int top_mark;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b1;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_SEARCH_MODE;
        cfg_data     = '0;
        no_idle      = 1'b0;
        words_sent   = 0;
        streams_sent = 0;
        reg_writes   = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // short streams under reset settings, then in last mode: all fail
        send_word('0, 1'b0);
        send_word('1, 1'b0);
        send_word(SYNC_WORD, 1'b0);
        send_word(32'h5555_AAAA, 1'b0);
        send_word(SYNC_WORD, 1'b1);
        send_word(SYNC_WORD, 1'b1);
        wait_idle();
        write_reg(CFG_SEARCH_MODE, CFG_DATA_W'(1));
        send_word('1, 1'b1);
        send_word(SYNC_WORD, 1'b0);
        send_word(SYNC_WORD, 1'b1);

        // first mode, earliest pair wins; no idling on either side here
        set_regs(1'b0, 22528, 56000);
        no_idle = 1'b1;
        sync_mark[3]  = 1'b1;
        sync_mark[10] = 1'b1;
        send_stream(2600, 1, -1);
        no_idle = 1'b0;

        // last mode, second pair turns up while headers of the first are due
        set_regs(1'b1, 22528, 1200);
        sync_mark[5] = 1'b1;
        sync_mark[6] = 1'b1;
        send_stream(2516, 1, -1);

        // headers cut off by the last word; start at the limit is refused
        set_regs(1'b1, 8, 99999);
        sync_mark[7] = 1'b1;
        send_stream(2512, 0, -1);
        sync_mark[7] = 1'b1;
        sync_mark[8] = 1'b1;
        send_stream(2514, 0, -1);

        // limit 0 forbids every pair; limit 1 allows only start 0
        set_regs(1'b0, 0, 56000);
        sync_mark[0] = 1'b1;
        send_stream(2510, 0, -1);
        set_regs(1'b0, 1, 56000);
        sync_mark[0] = 1'b1;
        send_stream(2506, 0, -1);

        // mode switched between the two pairs
        set_regs(1'b0, 22528, 60000);
        sync_mark[20] = 1'b1;
        sync_mark[40] = 1'b1;
        send_stream(2600, 1, 2530);

        // random mix: mostly short failing streams, some full frame pairs
        for (int r = 0; r < 48; r++) begin
            if ($urandom_range(5) == 0) random_regs();
            if (r % 8 == 7) begin
                top_mark = 0;
                repeat ($urandom_range(1, 3)) begin
                    len = $urandom_range(0, 150);
                    sync_mark[len] = 1'b1;
                    if (len > top_mark) top_mark = len;
                end
                len = FRAME_WORDS + top_mark + $urandom_range(0, 60) - 10;
                send_stream(len, 1, $urandom_range(1) ? $urandom_range(0, len - 1) : -1);
            end else begin
                send_stream($urandom_range(1, 60), 15, -1);
            end
        end

        wait_idle();
        $display("Run covered %0d words in %0d streams, %0d reports, %0d register writes.",
                 words_sent, streams_sent, reports_seen, reg_writes);
        $display("Both modes, limits 0 to 65535, day numbers 1200 to 99999, mode changes.");
        if (mismatches == 0 && reports_due == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
